FILE: hw/rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  localparam int CHAR_W    = 8;
  localparam int RROW_W    = 5;
  localparam int RCOL_W    = 7;
  localparam int CURCOL_W  = 7;
  localparam int CURROW_W  = 5;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic       CMD_PUT  = 1'b0;
  localparam logic       CMD_READ = 1'b1;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_BLANK   = 8'h20;
  localparam logic [7:0] CH_DEL     = 8'h7F;

  typedef struct packed {
    logic accept;
    logic put;
    logic read;
    logic sweep;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_read;
    logic put_scroll;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hw/rtl/tcw_ctrl.sv
module tcw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  tcw_pkg::dp_status_t status,
  output tcw_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_BLANK = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.item_read) begin
          cmd.read  = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          cmd.put   = 1'b1;
          state_nxt = status.put_scroll ? S_BLANK : S_EMIT;
        end
      end
      S_BLANK: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          in_tready = 1'b1;
          if (in_tvalid) begin
            cmd.accept = 1'b1;
            state_nxt  = S_EXEC;
          end else begin
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/tcw_datapath.sv
module tcw_datapath #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tcw_pkg::ctrl_cmd_t                  cmd,
  output tcw_pkg::dp_status_t                 status,
  input  logic                                in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]          in_char_code,
  input  logic [tcw_pkg::RROW_W-1:0]          in_read_row,
  input  logic [tcw_pkg::RCOL_W-1:0]          in_read_column,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [tcw_pkg::CHAR_W-1:0]          out_cell_code,
  output logic [tcw_pkg::CURCOL_W-1:0]        out_cursor_column,
  output logic [tcw_pkg::CURROW_W-1:0]        out_cursor_row
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(2 * CELLS + 32 * COLUMNS + 4 * TAB_STOP);
  localparam int CW    = $clog2(COLUMNS + 2 * TAB_STOP);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int PW    = $clog2(TAB_STOP) + 1;
  localparam int CM    = COLUMNS % TAB_STOP;

  logic [7:0] mem [CELLS];

  logic                        item_cmd_r;
  logic [tcw_pkg::CHAR_W-1:0]  item_char_r;
  logic [tcw_pkg::RROW_W-1:0]  item_row_r;
  logic [tcw_pkg::RCOL_W-1:0]  item_col_r;

  logic [CW-1:0] col_r,   col_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic [RW-1:0] row_r,   row_nxt;
  logic [AW-1:0] top_base_r;
  logic [AW-1:0] sweep_addr_r;
  logic [AW-1:0] sweep_cnt_r;
  logic          rd_ok_r;
  logic [7:0]    rd_data_r;
  logic          out_valid_r;
  logic [tcw_pkg::CHAR_W-1:0]   out_cell_r;
  logic [tcw_pkg::CURCOL_W-1:0] out_col_r;
  logic [tcw_pkg::CURROW_W-1:0] out_row_r;

  logic          is_tab, is_nl, is_print;
  logic [CW-1:0] col_a;
  logic [PW-1:0] phase_a;
  logic [RW-1:0] row_a;
  logic          wrap;
  logic          scroll;
  logic [IW-1:0] wr_idx, wr_sum, rd_idx, rd_sum;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_ok, rd_ok;

  assign is_tab   = (item_char_r == tcw_pkg::CH_TAB);
  assign is_nl    = (item_char_r == tcw_pkg::CH_NEWLINE);
  assign is_print = (item_char_r >= tcw_pkg::CH_BLANK) && (item_char_r <= tcw_pkg::CH_DEL);

  always_comb begin
    col_a   = col_r;
    phase_a = phase_r;
    row_a   = row_r;
    if (is_tab) begin
      col_a   = col_r + CW'(TAB_STOP) - CW'(phase_r);
      phase_a = '0;
    end else if (is_nl) begin
      col_a   = '0;
      phase_a = '0;
      row_a   = row_r + RW'(1);
    end else if (is_print) begin
      col_a   = col_r + CW'(1);
      phase_a = (phase_r == PW'(TAB_STOP - 1)) ? '0 : phase_r + PW'(1);
    end
    wrap      = (col_a >= CW'(COLUMNS));
    col_nxt   = col_a;
    phase_nxt = phase_a;
    row_nxt   = row_a;
    if (wrap) begin
      col_nxt   = col_a - CW'(COLUMNS);
      phase_nxt = (phase_a >= PW'(CM)) ? phase_a - PW'(CM) : phase_a + PW'(TAB_STOP - CM);
      row_nxt   = row_a + RW'(1);
    end
    scroll = (row_nxt >= RW'(ROWS));
    if (scroll) begin
      row_nxt = RW'(ROWS - 1);
    end
  end

  always_comb begin
    wr_idx  = IW'(row_r) * IW'(COLUMNS) + IW'(col_r);
    wr_ok   = is_print && (wr_idx < IW'(CELLS));
    wr_sum  = wr_idx + IW'(top_base_r);
    wr_addr = (wr_sum >= IW'(CELLS)) ? AW'(wr_sum - IW'(CELLS)) : AW'(wr_sum);
    rd_idx  = IW'(item_row_r) * IW'(COLUMNS) + IW'(item_col_r);
    rd_ok   = (IW'(item_row_r) < IW'(ROWS)) && (IW'(item_col_r) < IW'(COLUMNS));
    rd_sum  = rd_idx + IW'(top_base_r);
    rd_addr = (rd_sum >= IW'(CELLS)) ? AW'(rd_sum - IW'(CELLS)) : AW'(rd_sum);
  end

  assign status.item_read  = (item_cmd_r == tcw_pkg::CMD_READ);
  assign status.put_scroll = scroll;
  assign status.sweep_last = (sweep_cnt_r == '0);
  assign status.out_free   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      mem[sweep_addr_r] <= tcw_pkg::CH_BLANK;
    end else if (cmd.put && wr_ok) begin
      mem[wr_addr] <= item_char_r;
    end
    if (cmd.read) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_cmd_r  <= in_command;
      item_char_r <= in_char_code;
      item_row_r  <= in_read_row;
      item_col_r  <= in_read_column;
    end
    if (cmd.read) begin
      rd_ok_r <= rd_ok;
    end
    if (cmd.emit) begin
      out_cell_r <= (status.item_read && rd_ok_r) ? rd_data_r : '0;
      out_col_r  <= tcw_pkg::CURCOL_W'(col_r);
      out_row_r  <= tcw_pkg::CURROW_W'(row_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      phase_r      <= '0;
      row_r        <= '0;
      top_base_r   <= '0;
      sweep_addr_r <= '0;
      sweep_cnt_r  <= AW'(CELLS - 1);
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.put) begin
        col_r   <= col_nxt;
        phase_r <= phase_nxt;
        row_r   <= row_nxt;
        if (scroll) begin
          sweep_addr_r <= top_base_r;
          sweep_cnt_r  <= AW'(COLUMNS - 1);
          top_base_r   <= (IW'(top_base_r) + IW'(COLUMNS) >= IW'(CELLS)) ?
                          '0 : top_base_r + AW'(COLUMNS);
        end
      end else if (cmd.sweep) begin
        sweep_addr_r <= sweep_addr_r + AW'(1);
        sweep_cnt_r  <= sweep_cnt_r - AW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid        = out_valid_r;
  assign out_cell_code     = out_cell_r;
  assign out_cursor_column = out_col_r;
  assign out_cursor_row    = out_row_r;

endmodule

FILE: hw/rtl/text_console_writer.sv
// Flow: a word is accepted, executed, then its result word is registered on out_tdata; a put
// that scrolls first blanks the bottom line through the single memory write port.
// in_tready is low while a word executes or a scroll blanks; a new word is taken as a result leaves.
// Reset: synchronous, active low; clears the cursor, then sweeps every cell to space
// with in_tready low.
module text_console_writer #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tcw_pkg::IN_DATA_W-1:0]     in_tdata,   // char_code, read_row, read_column
  input  logic                              in_tuser,   // command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0]    out_tdata   // cell_code, cursor_column, cursor_row
);

  tcw_pkg::ctrl_cmd_t  cmd;
  tcw_pkg::dp_status_t status;

  logic [tcw_pkg::CHAR_W-1:0]   cell_code;
  logic [tcw_pkg::CURCOL_W-1:0] cursor_column;
  logic [tcw_pkg::CURROW_W-1:0] cursor_row;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_command        (in_tuser),
    .in_char_code      (in_tdata[7:0]),
    .in_read_row       (in_tdata[12:8]),
    .in_read_column    (in_tdata[19:13]),
    .out_tready        (out_tready),
    .out_tvalid        (out_tvalid),
    .out_cell_code     (cell_code),
    .out_cursor_column (cursor_column),
    .out_cursor_row    (cursor_row)
  );

  assign out_tdata = {4'b0000, cursor_row, cursor_column, cell_code};

endmodule

FILE: test/text_console_checker.sv
module text_console_checker
  import tcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // char_code, read_row, read_column
  input  logic                  in_tuser,   // command
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // cell_code, cursor_column, cursor_row
  output int                    fail_count,
  output int                    pending,
  output int                    scroll_count,
  output int                    read_count
);

  typedef struct packed {
    logic [CURROW_W-1:0] row;
    logic [CURCOL_W-1:0] col;
    logic [CHAR_W-1:0]   code;
  } cursor_word_t;

  localparam int WORD_BITS = CHAR_W + CURCOL_W + CURROW_W;

  logic [CHAR_W-1:0] screen [ROWS_DEF][COLUMNS_DEF];
  int                cur_col;
  int                cur_row;
  int                fails;
  int                scrolls;
  int                reads;
  cursor_word_t      awaited_q [$];

  task automatic scroll_screen();
    for (int r = 0; r < ROWS_DEF - 1; r++) begin
      for (int c = 0; c < COLUMNS_DEF; c++) begin
        screen[r][c] = screen[r + 1][c];
      end
    end
    for (int c = 0; c < COLUMNS_DEF; c++) begin
      screen[ROWS_DEF - 1][c] = CH_BLANK;
    end
    scrolls++;
  endtask

  task automatic predict_console(input logic cmd, input logic [IN_DATA_W-1:0] data,
                                 output cursor_word_t res);
    logic [CHAR_W-1:0] ch;
    int                rr;
    int                rc;
    ch = data[CHAR_W-1:0];
    rr = int'(data[CHAR_W +: RROW_W]);
    rc = int'(data[CHAR_W + RROW_W +: RCOL_W]);
    res.code = '0;
    if (cmd == CMD_PUT) begin
      if (ch == CH_TAB) begin
        cur_col = cur_col + TAB_STOP_DEF - cur_col % TAB_STOP_DEF;
      end else if (ch == CH_NEWLINE) begin
        cur_col = 0;
        cur_row++;
      end else if (ch >= CH_BLANK && ch <= CH_DEL) begin
        screen[cur_row][cur_col] = ch;
        cur_col++;
      end
      if (cur_col >= COLUMNS_DEF) begin
        cur_col -= COLUMNS_DEF;
        cur_row++;
      end
      if (cur_row >= ROWS_DEF) begin
        scroll_screen();
        cur_row = ROWS_DEF - 1;
      end
    end else begin
      reads++;
      if (rr < ROWS_DEF && rc < COLUMNS_DEF) res.code = screen[rr][rc];
    end
    res.col = cur_col[CURCOL_W-1:0];
    res.row = cur_row[CURROW_W-1:0];
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    cursor_word_t want;
    cursor_word_t got;
    if (!rst_n) begin
      for (int r = 0; r < ROWS_DEF; r++) begin
        for (int c = 0; c < COLUMNS_DEF; c++) begin
          screen[r][c] = CH_BLANK;
        end
      end
      cur_col = 0;
      cur_row = 0;
      fails   = 0;
      scrolls = 0;
      reads   = 0;
      awaited_q.delete();
    end else begin
      // retire results before taking a new word; a result never belongs to a word of this edge
      if (out_tvalid && out_tready) begin
        got = out_tdata[WORD_BITS-1:0];
        if (awaited_q.size() == 0) begin
          $error("result word %0h arrived with nothing awaited", out_tdata);
          fails++;
        end else begin
          want = awaited_q.pop_front();
          compare_field("cell_code", 32'(want.code), 32'(got.code));
          compare_field("cursor_column", 32'(want.col), 32'(got.col));
          compare_field("cursor_row", 32'(want.row), 32'(got.row));
          compare_field("padding", '0, 32'(out_tdata[OUT_DATA_W-1:WORD_BITS]));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_console(in_tuser, in_tdata, want);
        awaited_q.push_back(want);
      end
    end
    fail_count   <= fails;
    pending      <= awaited_q.size();
    scroll_count <= scrolls;
    read_count   <= reads;
  end

endmodule

FILE: test/tb.sv
module tb;
  import tcw_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 300;
  localparam int PHASE_WORDS  = 450;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = CMD_PUT;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int pending;
  int scroll_count;
  int read_count;
  int words_sent   = 0;
  int idle_cycles  = 0;
  int sender_pct   = 0;
  int receiver_pct = 0;

  always #5 clk = ~clk;

  text_console_writer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  text_console_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .scroll_count (scroll_count),
    .read_count   (read_count)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_word(input logic [CHAR_W-1:0] ch,
                                                     input logic [RROW_W-1:0] rr,
                                                     input logic [RCOL_W-1:0] rc);
    return {rc, rr, ch};
  endfunction

  task automatic push_word(input logic cmd, input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(99) < sender_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic random_word(output logic cmd, output logic [IN_DATA_W-1:0] data);
    logic [CHAR_W-1:0] ch;
    logic [RROW_W-1:0] rr;
    logic [RCOL_W-1:0] rc;
    int                pick;
    ch = CHAR_W'($urandom_range(255));
    rr = RROW_W'($urandom_range(31));
    rc = RCOL_W'($urandom_range(127));
    if ($urandom_range(99) < 75) begin
      cmd  = CMD_PUT;
      pick = $urandom_range(99);
      if (pick < 70) ch = CHAR_W'($urandom_range(CH_DEL, CH_BLANK));
      else if (pick < 82) ch = CH_NEWLINE;
      else if (pick < 90) ch = CH_TAB;
    end else begin
      cmd = CMD_READ;
      if ($urandom_range(9) != 0) begin
        rr = RROW_W'($urandom_range(ROWS_DEF - 1));
        rc = RCOL_W'($urandom_range(COLUMNS_DEF - 1));
      end
    end
    data = pack_word(ch, rr, rc);
  endtask

  initial begin
    logic [CHAR_W-1:0]    probe_bytes [10];
    logic                 cmd;
    logic [IN_DATA_W-1:0] data;
    probe_bytes = '{8'h20, 8'h7E, CH_DEL, 8'h41, 8'h00, 8'h1F, 8'h80, 8'hFF, 8'h0D, CH_TAB};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    push_word(CMD_READ, pack_word(8'h00, 5'd0, 7'd0));
    foreach (probe_bytes[i]) push_word(CMD_PUT, pack_word(probe_bytes[i], 5'h1F, 7'h7F));
    push_word(CMD_READ, pack_word(8'hFF, 5'd0, 7'd1));
    push_word(CMD_READ, pack_word(8'hFF, 5'd24, 7'd79));
    push_word(CMD_READ, pack_word(8'hFF, 5'd25, 7'd0));
    push_word(CMD_READ, pack_word(8'hFF, 5'h1F, 7'h7F));
    push_word(CMD_READ, pack_word(8'hFF, 5'd0, 7'd80));
    // run the tab stops out to the line end and over the wrap
    repeat (COLUMNS_DEF / TAB_STOP_DEF - 1) push_word(CMD_PUT, pack_word(CH_TAB, 5'd0, 7'd0));
    push_word(CMD_PUT, pack_word(CH_NEWLINE, 5'd0, 7'd0));

    for (int p = 0; p < 4; p++) begin
      sender_pct   = (p == 1) ? 56 : (p == 3) ? 31 : 0;
      receiver_pct <= (p == 2) ? 56 : (p == 3) ? 31 : 0;
      repeat (PHASE_WORDS) begin
        random_word(cmd, data);
        push_word(cmd, data);
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words in four handshake phases: %0d cell reads, %0d screen scrolls",
             words_sent, read_count, scroll_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_datapath.sv
hw/rtl/text_console_writer.sv
test/text_console_checker.sv
test/tb.sv
